@@ design/hsl_pkg.sv @@
package hsl_pkg;

	localparam int SEG_N  = 8;
	localparam int SEG_W  = 3;
	localparam int SR_W   = 24;
	localparam int RES_W  = 23;
	localparam int DR_W   = 22;
	localparam int HUM_W  = 14;
	localparam int DH_W   = 11;
	localparam int NUM2_W = 34;
	localparam int DIV_W  = 29;
	localparam int Q_W    = 7;

	localparam logic [SR_W-1:0]  SR_RESET = 24'd1040000;
	localparam logic [RES_W-1:0] RES_MAX  = 23'd5764705;

	typedef logic [RES_W-1:0]  res_arr_t [SEG_N+1];
	typedef logic [HUM_W-1:0]  hum_arr_t [SEG_N+1];
	typedef logic [RES_W-1:0]  lo_arr_t  [SEG_N];
	typedef logic [DH_W-1:0]   dh_arr_t  [SEG_N];
	typedef logic [NUM2_W-1:0] top_arr_t [SEG_N];
	typedef logic [DIV_W-1:0]  div_arr_t [SEG_N];

	// breakpoints, high to low resistance; humidity in hundredths of a percent
	localparam res_arr_t SEG_RES = '{
		23'd5764705, 23'd2588235, 23'd1000000, 23'd629411, 23'd100000,
		23'd84117, 23'd47058, 23'd10000, 23'd3117
	};
	localparam hum_arr_t SEG_HUM = '{
		14'd2272, 14'd2727, 14'd3000, 14'd3727, 14'd4863,
		14'd5227, 14'd6272, 14'd7272, 14'd9272
	};

	function automatic lo_arr_t mk_lo();
		lo_arr_t a;
		for (int i = 0; i < SEG_N; i++) a[i] = SEG_RES[i+1];
		return a;
	endfunction

	function automatic dh_arr_t mk_dh();
		dh_arr_t a;
		for (int i = 0; i < SEG_N; i++) a[i] = DH_W'(SEG_HUM[i+1] - SEG_HUM[i]);
		return a;
	endfunction

	// hum_hi * width of segment
	function automatic top_arr_t mk_top();
		top_arr_t a;
		for (int i = 0; i < SEG_N; i++)
			a[i] = NUM2_W'(SEG_HUM[i+1]) * NUM2_W'(SEG_RES[i] - SEG_RES[i+1]);
		return a;
	endfunction

	// 100 * width of segment
	function automatic div_arr_t mk_div();
		div_arr_t a;
		for (int i = 0; i < SEG_N; i++)
			a[i] = DIV_W'(100) * DIV_W'(SEG_RES[i] - SEG_RES[i+1]);
		return a;
	endfunction

	localparam lo_arr_t  SEG_LO  = mk_lo();
	localparam dh_arr_t  SEG_DH  = mk_dh();
	localparam top_arr_t SEG_TOP = mk_top();
	localparam div_arr_t SEG_DIV = mk_div();

	typedef struct packed {
		logic [NUM2_W-1:0] num;
		logic [DIV_W-1:0]  div;
		logic              oor;
	} seg_out_t;

endpackage

@@ design/humidity_sensor_linearizer_unit.sv @@
// Humidity sensor linearizer. Each transfer on the s_ side carries one
// converter reading of a resistive humidity sensor in a divider with the
// series resistor set through cfg_wen/cfg_wdata (ohms, reset 1040000). The
// sensor resistance sample*R/(2^ADC_BITS - sample) is mapped through an
// 8-segment piecewise-linear table and the humidity comes out truncated to
// whole percent on m_tdata; m_tuser flags a resistance outside
// 3117..5764705 ohms, with humidity 0. One sample is taken every cycle
// while m_tready does not hold the output back; the pipeline is the resistance
// divider, a product stage followed by one quotient bit per stage over
// ADC_BITS+24 stages, plus four table/multiply stages and seven stages of
// the final division.
// Write the resistor only while no sample is in flight.
module humidity_sensor_linearizer_unit #(
	parameter int ADC_BITS = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [hsl_pkg::SR_W-1:0]         cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [((ADC_BITS+7)/8)*8-1:0]    s_tdata,   // adc_sample
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,   // humidity_percent
	output logic                             m_tuser    // out_of_range
);
	import hsl_pkg::*;

	logic [SR_W-1:0]  series_resistance_q;
	logic             div_valid, div_ready;
	logic [RES_W-1:0] res;
	logic             seg_valid, seg_ready;
	seg_out_t         seg_data;
	logic [Q_W-1:0]   hum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_resistance_q <= SR_RESET;
		end else if (cfg_wen) begin
			series_resistance_q <= cfg_wdata;
		end
	end

	hsl_rdiv #(
		.ADC_BITS (ADC_BITS)
	) u_rdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.sample    (s_tdata[ADC_BITS-1:0]),
		.rs        (series_resistance_q),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.r         (res)
	);

	hsl_seg u_seg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.r         (res),
		.out_valid (seg_valid),
		.out_ready (seg_ready),
		.dout      (seg_data)
	);

	hsl_qdiv u_qdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seg_valid),
		.in_ready  (seg_ready),
		.din       (seg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.hum       (hum),
		.oor       (m_tuser)
	);

	assign m_tdata = {1'b0, hum};

endmodule

@@ design/hsl_rdiv.sv @@
// resistance = sample * rs / (2^ADC_BITS - sample), one quotient bit per stage
module hsl_rdiv #(
	parameter int ADC_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ADC_BITS-1:0]        sample,
	input  logic [hsl_pkg::SR_W-1:0]   rs,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [hsl_pkg::RES_W-1:0]  r
);
	import hsl_pkg::*;

	localparam int NUM_W = ADC_BITS + SR_W;
	localparam int DEN_W = ADC_BITS + 1;
	localparam int LAST  = NUM_W;

	logic             v_s   [0:LAST];
	logic             rdy   [0:LAST];
	logic [NUM_W-1:0] nq_s  [0:LAST];
	logic [DEN_W-1:0] rem_s [0:LAST-1];
	logic [DEN_W-1:0] den_s [0:LAST-1];

	assign in_ready  = rdy[0];
	assign out_valid = v_s[LAST];
	assign rdy[0]    = !v_s[0] || rdy[1];
	assign rdy[LAST] = !v_s[LAST] || out_ready;

	// quotient wider than the table saturates, it is out of range anyway
	assign r = (|nq_s[LAST][NUM_W-1:RES_W]) ? {RES_W{1'b1}} : nq_s[LAST][RES_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			nq_s[0]  <= NUM_W'(sample) * NUM_W'(rs);
			rem_s[0] <= '0;
			den_s[0] <= {1'b1, {ADC_BITS{1'b0}}} - {1'b0, sample};
		end
	end

	genvar k;
	generate
		for (k = 1; k <= LAST; k++) begin : g_stage
			logic [DEN_W:0]   trial;
			logic             ge;
			logic [DEN_W:0]   diff;

			if (k < LAST) begin : g_rdy
				assign rdy[k] = !v_s[k] || rdy[k+1];
			end

			assign trial  = {rem_s[k-1], nq_s[k-1][NUM_W-1]};
			assign ge     = trial >= {1'b0, den_s[k-1]};
			assign diff   = trial - {1'b0, den_s[k-1]};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (rdy[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k]) begin
					nq_s[k] <= {nq_s[k-1][NUM_W-2:0], ge};
				end
			end

			if (k < LAST) begin : g_rem
				always_ff @(posedge clk) begin
					if (rdy[k]) begin
						rem_s[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
						den_s[k] <= den_s[k-1];
					end
				end
			end
		end
	endgenerate

endmodule

@@ design/hsl_seg.sv @@
// segment lookup and interpolation numerator, four stages
module hsl_seg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [hsl_pkg::RES_W-1:0]  r,
	output logic                       out_valid,
	input  logic                       out_ready,
	output hsl_pkg::seg_out_t          dout
);
	import hsl_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic [SEG_W-1:0]  seg_s1, seg_s2, seg_s3;
	logic [RES_W-1:0]  r_s1;
	logic              oor_s1, oor_s2, oor_s3;
	logic [DR_W-1:0]   rl_s2;
	logic [NUM2_W-1:0] prod_s3;
	seg_out_t          out_s4;

	logic [SEG_W-1:0] seg_sel;
	logic             oor_sel;
	logic [RES_W-1:0] rl_full;

	assign rdy4      = !v_s4 || out_ready;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign in_ready  = rdy1;
	assign out_valid = v_s4;
	assign dout      = out_s4;

	// on a shared end the lower index (higher resistance) wins
	always_comb begin
		oor_sel = (r > RES_MAX) || (r < SEG_LO[SEG_N-1]);
		seg_sel = '0;
		for (int i = SEG_N - 1; i >= 0; i--) begin
			if (r >= SEG_LO[i]) seg_sel = SEG_W'(i);
		end
	end

	assign rl_full = r_s1 - SEG_LO[seg_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			seg_s1 <= seg_sel;
			r_s1   <= r;
			oor_s1 <= oor_sel;
		end
		if (rdy2) begin
			seg_s2 <= seg_s1;
			oor_s2 <= oor_s1;
			rl_s2  <= rl_full[DR_W-1:0];
		end
		if (rdy3) begin
			seg_s3  <= seg_s2;
			oor_s3  <= oor_s2;
			prod_s3 <= NUM2_W'(rl_s2) * NUM2_W'(SEG_DH[seg_s2]);
		end
		if (rdy4) begin
			// zero numerator gives a zero quotient when out of range
			out_s4.num <= oor_s3 ? '0 : SEG_TOP[seg_s3] - prod_s3;
			out_s4.div <= SEG_DIV[seg_s3];
			out_s4.oor <= oor_s3;
		end
	end

endmodule

@@ design/hsl_qdiv.sv @@
// num / div restoring division, one quotient bit per stage, MSB first
module hsl_qdiv (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  hsl_pkg::seg_out_t        din,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [hsl_pkg::Q_W-1:0]  hum,
	output logic                     oor
);
	import hsl_pkg::*;

	localparam int LAST = Q_W - 1;
	localparam int SHW  = DIV_W + Q_W - 1;

	logic              v_s   [0:LAST];
	logic              rdy   [0:LAST];
	logic [NUM2_W-1:0] rem_s [0:LAST];
	logic [Q_W-1:0]    q_s   [0:LAST];
	logic              oor_s [0:LAST];
	logic [DIV_W-1:0]  div_s [0:LAST-1];

	assign in_ready  = rdy[0];
	assign out_valid = v_s[LAST];
	assign hum       = q_s[LAST];
	assign oor       = oor_s[LAST];
	assign rdy[LAST] = !v_s[LAST] || out_ready;

	genvar j;
	generate
		for (j = 0; j <= LAST; j++) begin : g_stage
			logic              v_in;
			logic [NUM2_W-1:0] rem_in;
			logic [DIV_W-1:0]  div_in;
			logic [Q_W-1:0]    q_in;
			logic              oor_in;
			logic [SHW-1:0]    shifted;
			logic [SHW-1:0]    diff;
			logic              ge;

			if (j == 0) begin : g_first
				assign v_in   = in_valid;
				assign rem_in = din.num;
				assign div_in = din.div;
				assign q_in   = '0;
				assign oor_in = din.oor;
			end else begin : g_next
				assign v_in   = v_s[j-1];
				assign rem_in = rem_s[j-1];
				assign div_in = div_s[j-1];
				assign q_in   = q_s[j-1];
				assign oor_in = oor_s[j-1];
			end

			if (j < LAST) begin : g_rdy
				assign rdy[j] = !v_s[j] || rdy[j+1];
				always_ff @(posedge clk) begin
					if (rdy[j]) div_s[j] <= div_in;
				end
			end

			assign shifted = SHW'(div_in) << (LAST - j);
			assign ge      = SHW'(rem_in) >= shifted;
			assign diff    = SHW'(rem_in) - shifted;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[j] <= 1'b0;
				end else if (rdy[j]) begin
					v_s[j] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[j]) begin
					rem_s[j] <= ge ? diff[NUM2_W-1:0] : rem_in;
					q_s[j]   <= {q_in[Q_W-2:0], ge};
					oor_s[j] <= oor_in;
				end
			end
		end
	endgenerate

endmodule

@@ bench/tb.sv @@
module tb;
	import hsl_pkg::*;

	localparam int LIMIT_CYCLES = 300000;
	localparam int TAIL_CYCLES  = 64;

	typedef struct packed {
		logic [6:0] hum;
		logic       oor;
	} reading_t;

	// breakpoints, high to low resistance; humidity in hundredths of a percent
	localparam longint unsigned BP_OHMS [9] = '{
		5764705, 2588235, 1000000, 629411, 100000, 84117, 47058, 10000, 3117
	};
	localparam longint unsigned BP_HUM [9] = '{
		2272, 2727, 3000, 3727, 4863, 5227, 6272, 7272, 9272
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [SR_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tuser;

	logic [SR_W-1:0] resistor_ohms = SR_RESET;
	reading_t pending_readings [$];
	bit gap_en = 1'b1;
	bit stall_en = 1'b1;
	int errors = 0;
	int n_samples = 0;
	int n_readings = 0;
	int n_oor = 0;
	int n_writes = 0;
	int cycles = 0;
	int stall_left = 0;

	humidity_sensor_linearizer_unit #(.ADC_BITS(10)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic reading_t humidity_of(input logic [9:0] smp, input logic [SR_W-1:0] ohms);
		longint unsigned r, d, n;
		reading_t res;
		res.hum = '0;
		res.oor = 1'b1;
		r = (64'(smp) * 64'(ohms)) / (64'd1024 - 64'(smp));
		for (int i = 0; i < 8; i++) begin
			// on a shared end the higher-resistance segment is taken first
			if (res.oor && r <= BP_OHMS[i] && r >= BP_OHMS[i+1]) begin
				d = BP_OHMS[i] - BP_OHMS[i+1];
				n = (r - BP_OHMS[i+1]) * (BP_HUM[i+1] - BP_HUM[i]);
				res.hum = 7'((BP_HUM[i+1] * d - n) / (100 * d));
				res.oor = 1'b0;
			end
		end
		return res;
	endfunction

	// track resistor writes, queue predictions per input transfer, check outputs
	always @(posedge clk) begin
		reading_t want;
		if (arst_n) begin
			if (cfg_wen)
				resistor_ohms = cfg_wdata;
			if (s_tvalid && s_tready) begin
				pending_readings.push_back(humidity_of(s_tdata[9:0], resistor_ohms));
				n_samples++;
			end
			if (m_tvalid && m_tready) begin
				if (pending_readings.size() == 0) begin
					$display("%0t: unexpected reading hum=%0d oor=%0b", $time, m_tdata, m_tuser);
					errors++;
				end else begin
					want = pending_readings.pop_front();
					n_readings++;
					if (want.oor)
						n_oor++;
					if (m_tdata !== {1'b0, want.hum}) begin
						$display("%0t: humidity expected %0d got %0d", $time, want.hum, m_tdata);
						errors++;
					end
					if (m_tuser !== want.oor) begin
						$display("%0t: out_of_range expected %0b got %0b", $time, want.oor,
							m_tuser);
						errors++;
					end
				end
			end
		end
	end

	// output backpressure in bursts
	always @(posedge clk) begin
		if (stall_left == 0 && stall_en && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 11);
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left = stall_left - 1;
		end else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout, %0d readings outstanding", $time, pending_readings.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic push_sample(input logic [9:0] smp);
		int gap;
		if (gap_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, smp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// stop sending and wait until every queued reading has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_readings.size() != 0);
	endtask

	task automatic write_resistor(input logic [SR_W-1:0] ohms);
		drain();
		cfg_wen <= 1'b1;
		cfg_wdata <= ohms;
		@(posedge clk);
		cfg_wen <= 1'b0;
		n_writes++;
	endtask

	// reset resistor value, across the divider range: low-end cutoff near
	// sample 3..4, high-end cutoff near sample 867
	task automatic test_divider_sweep();
		int pts [25] = '{0, 1, 2, 3, 4, 5, 6, 100, 200, 300, 400, 500, 512, 600, 700,
			800, 850, 860, 866, 867, 868, 900, 1000, 1022, 1023};
		foreach (pts[i])
			push_sample(10'(pts[i]));
	endtask

	// sample 512 makes resistance equal the resistor: hit every breakpoint and
	// its neighbors, including both table edges
	task automatic test_breakpoints();
		for (int i = 0; i < 9; i++) begin
			for (int k = -1; k <= 1; k++) begin
				write_resistor(SR_W'(longint'(BP_OHMS[i]) + k));
				push_sample(10'd512);
			end
		end
	endtask

	task automatic test_resistor_extremes();
		logic [SR_W-1:0] vals [3] = '{24'd0, 24'd1, 24'hFFFFFF};
		foreach (vals[v]) begin
			write_resistor(vals[v]);
			push_sample(10'd0);
			push_sample(10'd1023);
			push_sample(10'd512);
			push_sample(10'h2AA);
			push_sample(10'h155);
			repeat (10)
				push_sample(10'($urandom_range(0, 1023)));
		end
	endtask

	task automatic test_random_readings();
		write_resistor(SR_RESET);
		repeat (100)
			push_sample(10'($urandom_range(0, 1023)));
		// pause until the block is empty, then carry on
		drain();
		repeat (100)
			push_sample(10'($urandom_range(0, 1023)));
		for (int p = 0; p < 3; p++) begin
			write_resistor(SR_W'($urandom_range(200000, 3000000)));
			repeat (100)
				push_sample(10'($urandom_range(0, 1023)));
		end
		write_resistor(SR_W'($urandom_range(0, 24'hFFFFFF)));
		repeat (60)
			push_sample(10'($urandom_range(0, 1023)));
		// closing stretch at full rate on both sides
		write_resistor(SR_RESET);
		gap_en = 1'b0;
		stall_en = 1'b0;
		repeat (100)
			push_sample(10'($urandom_range(0, 1023)));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_divider_sweep();
		test_breakpoints();
		test_resistor_extremes();
		test_random_readings();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d samples over %0d resistor settings (zero, one, full scale,",
			n_samples, n_writes);
		$display("every breakpoint); %0d readings checked, %0d outside the table",
			n_readings, n_oor);
		if (errors == 0 && pending_readings.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
